>>> hw/rtl/nsd_pkg.sv
// nsd_pkg: types, codes and constants shared by the netstring deframer
// no dependencies; used by nsd_parser and netstring_deframer
package nsd_pkg;

  localparam int unsigned LEN_W       = 11;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned ACC_W       = LEN_W + 4;

  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = LEN_W'(1024);
  localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3a;
  localparam logic [BYTE_W-1:0] CH_COMMA      = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE       = 8'h39;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_COMMA   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_CHAR      = 2'd1,
    ERR_TOO_LARGE = 2'd2,
    ERR_NO_COMMA  = 2'd3
  } err_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    err_t              err;
  } result_t;

endpackage

>>> hw/rtl/nsd_parser.sv
// nsd_parser: parse phase, length accumulator and payload counter
// one byte per enabled cycle; result is combinational; uses nsd_pkg
module nsd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [nsd_pkg::BYTE_W-1:0] step_byte,
  input  logic [nsd_pkg::LEN_W-1:0]  max_length,
  output nsd_pkg::result_t           res
);

  nsd_pkg::phase_t                phase_r, phase_nxt;
  logic [nsd_pkg::LEN_W-1:0]      accum_r, accum_nxt;
  logic [nsd_pkg::LEN_W-1:0]      remain_r, remain_nxt;
  logic [nsd_pkg::LEN_W-1:0]      limit;
  logic [nsd_pkg::LEN_W-1:0]      remain_dec;
  logic [nsd_pkg::ACC_W-1:0]      next_len;
  logic                           is_digit;

  assign limit = (max_length > nsd_pkg::LEN_W'(nsd_pkg::MAX_PAYLOAD))
               ? nsd_pkg::LEN_W'(nsd_pkg::MAX_PAYLOAD) : max_length;
  assign is_digit = (step_byte >= nsd_pkg::CH_ZERO) && (step_byte <= nsd_pkg::CH_NINE);
  assign next_len = (nsd_pkg::ACC_W'(accum_r) << 3) + (nsd_pkg::ACC_W'(accum_r) << 1)
                  + nsd_pkg::ACC_W'(step_byte[3:0]);
  assign remain_dec = (remain_r != '0) ? remain_r - 1'b1 : remain_r;

  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    remain_nxt = remain_r;
    res        = '{vld: 1'b0, kind: nsd_pkg::KIND_BYTE, data: '0, len: '0,
                   err: nsd_pkg::ERR_NONE};
    case (phase_r)
      nsd_pkg::PH_PAYLOAD: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) phase_nxt = nsd_pkg::PH_COMMA;
        res.vld  = 1'b1;
        res.data = step_byte;
      end
      nsd_pkg::PH_COMMA: begin
        phase_nxt  = nsd_pkg::PH_LENGTH;
        accum_nxt  = '0;
        remain_nxt = '0;
        res.vld    = 1'b1;
        if (step_byte == nsd_pkg::CH_COMMA) begin
          res.kind = nsd_pkg::KIND_END;
          res.len  = accum_r;
        end else begin
          res.kind = nsd_pkg::KIND_ERROR;
          res.err  = nsd_pkg::ERR_NO_COMMA;
        end
      end
      default: begin
        if (is_digit) begin
          if (next_len > nsd_pkg::ACC_W'(limit)) begin
            phase_nxt  = nsd_pkg::PH_LENGTH;
            accum_nxt  = '0;
            remain_nxt = '0;
            res.vld    = 1'b1;
            res.kind   = nsd_pkg::KIND_ERROR;
            res.err    = nsd_pkg::ERR_TOO_LARGE;
          end else begin
            phase_nxt = nsd_pkg::PH_LENGTH;
            accum_nxt = next_len[nsd_pkg::LEN_W-1:0];
          end
        end else if (step_byte == nsd_pkg::CH_COLON) begin
          remain_nxt = accum_r;
          phase_nxt  = (accum_r == '0) ? nsd_pkg::PH_COMMA : nsd_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt  = nsd_pkg::PH_LENGTH;
          accum_nxt  = '0;
          remain_nxt = '0;
          res.vld    = 1'b1;
          res.kind   = nsd_pkg::KIND_ERROR;
          res.err    = nsd_pkg::ERR_CHAR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= nsd_pkg::PH_LENGTH;
      accum_r  <= '0;
      remain_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

>>> hw/rtl/netstring_deframer.sv
// netstring_deframer: top level, input register, parser and result register
// depends on nsd_pkg and nsd_parser
//
//   channel  handshake          payload
//   in       in_valid/in_stall  in_rx_byte
//   out      out_valid/out_stall out_kind, out_byte, out_frame_length, out_error_code
//   cfg      cfg_valid/cfg_ready cfg_max_length
//
// one byte per cycle sustained unless out_stall holds the result; a byte waits in
// the input register and its result, if any, is registered into the result
// register as the parser steps; the parser state update between them sets the rate
// out_stall holds the result register and backs up into in_stall the same cycle
// synchronous active-low reset clears state, valids and max_length (to 1024)
module netstring_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [10:0] out_frame_length,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_max_length
);

  logic                          in_vld_r, in_vld_nxt;
  logic [nsd_pkg::BYTE_W-1:0]    in_byte_r;
  logic                          out_vld_r, out_vld_nxt;
  nsd_pkg::result_t              out_res_r;
  nsd_pkg::result_t              res;
  logic [nsd_pkg::LEN_W-1:0]     max_len_r;
  logic                          adv;
  logic                          step_en;
  logic                          in_acc;

  assign adv      = !out_vld_r || !out_stall;
  assign step_en  = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  nsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .step_byte  (in_byte_r),
    .max_length (max_len_r),
    .res        (res)
  );

  always_comb begin
    if (in_acc) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    else in_vld_nxt = in_vld_r;
    out_vld_nxt = adv ? (step_en && res.vld) : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      max_len_r <= nsd_pkg::MAX_LEN_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) max_len_r <= cfg_max_length;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_byte_r <= in_rx_byte;
    if (step_en && res.vld) out_res_r <= res;
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_res_r.kind;
  assign out_byte         = out_res_r.data;
  assign out_frame_length = out_res_r.len;
  assign out_error_code   = out_res_r.err;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == nsd_pkg::KIND_END) |->
      (out_frame_length <= nsd_pkg::LEN_W'(nsd_pkg::MAX_PAYLOAD)))
    else $error("frame length above limit");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == nsd_pkg::KIND_ERROR) |-> out_error_code != nsd_pkg::ERR_NONE)
    else $error("frame error without a code");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != nsd_pkg::KIND_BYTE) |-> out_byte == '0)
    else $error("nonzero byte on a frame report");

endmodule
